// ----- sv/nsf_pkg.sv -----
// Package for the NMEA sentence framer: result codes, limits and the result word type.
package nsf_pkg;

    localparam int FRAME_BYTES = 128;

    localparam logic [15:0] FRAME_GAP_RESET = 16'd1000;
    localparam logic [15:0] CHAR_GAP_RESET  = 16'd100;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_START    = 3'd1;
    localparam logic [2:0] EV_CHAR     = 3'd2;
    localparam logic [2:0] EV_CS_OK    = 3'd3;
    localparam logic [2:0] EV_COMPLETE = 3'd4;
    localparam logic [2:0] EV_DROP     = 3'd5;
    localparam logic [2:0] EV_TIMEOUT  = 3'd6;

    localparam logic [1:0] CAUSE_NONE     = 2'd0;
    localparam logic [1:0] CAUSE_TOO_LONG = 2'd1;
    localparam logic [1:0] CAUSE_CHECKSUM = 2'd2;
    localparam logic [1:0] CAUSE_NO_LF    = 2'd3;

    localparam logic [0:0] REG_FRAME_GAP = 1'b0;
    localparam logic [0:0] REG_CHAR_GAP  = 1'b1;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] HEX_ALPHA_OFFSET = 8'd55;

    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] drop_cause;
        logic [7:0] running_xor;
        logic [6:0] body_length;
        logic [6:0] char_index;
        logic [7:0] body_char;
    } res_t;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c > CH_NINE) begin
            v = c - HEX_ALPHA_OFFSET;
        end else begin
            v = c - CH_ZERO;
        end
        return v;
    endfunction

endpackage

// ----- sv/nmea_sentence_framer_unit.sv -----
// Top level of the NMEA sentence framer: framing, checksum, timeouts and output skid stage.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser is the command
//   (0 = received byte in s_tdata, 1 = one time tick without a byte).
//   Every accepted input word yields exactly one result word on m_tvalid/m_tready,
//   with the event code in m_tuser and the payload fields packed in m_tdata.
//   The result word is registered; one word per cycle is sustained while the
//   receiver keeps m_tready high.
//   A second (skid) register holds one result while the receiver stalls, so one
//   more input word is taken during a stall; s_tready then drops until the
//   receiver takes a word.
//   Timeouts are written through cfg_we/cfg_index/cfg_data; the user must write them
//   only while idle, as the block does not enforce it; index 0 is the frame gap
//   timeout, index 1 the character gap timeout. Reset (aresetn low, synchronous)
//   empties both output registers, returns the framer to waiting for '$', clears
//   counters and checksum, and restores the timeouts to 1000 and 100 ticks.
module nmea_sentence_framer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    // body_char[7:0], char_index[14:8], body_length[21:15], running_xor[29:22],
    // drop_cause[31:30]
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,   // event_res
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [1:0] PH_WAIT_START = 2'd0;
    localparam logic [1:0] PH_BODY       = 2'd1;
    localparam logic [1:0] PH_WAIT_LF    = 2'd2;
    localparam logic [1:0] PH_CHECKSUM   = 2'd3;

    localparam logic [6:0] BODY_LIMIT = 7'(nsf_pkg::FRAME_BYTES - 1);

    logic [15:0] frame_gap_reg;
    logic [15:0] char_gap_reg;

    logic [1:0]  phase_reg, phase_next;
    logic [6:0]  body_count_reg, body_count_next;
    logic [7:0]  xor_reg, xor_next;
    logic        hex_seen_reg, hex_seen_next;
    logic [7:0]  hex_high_reg, hex_high_next;
    logic [15:0] idle_reg, idle_next;
    logic        inside_reg, inside_next;

    nsf_pkg::res_t res_next;
    nsf_pkg::res_t out_reg;
    nsf_pkg::res_t skid_reg;
    logic          out_valid_reg;
    logic          skid_valid_reg;

    logic        accept;
    logic        out_free;
    logic [7:0]  hv;
    logic [7:0]  rx_sum;
    logic [15:0] limit;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {out_reg.drop_cause, out_reg.running_xor, out_reg.body_length,
                       out_reg.char_index, out_reg.body_char};

    assign hv     = nsf_pkg::hex_value(s_tdata);
    assign rx_sum = {hex_high_reg[3:0], 4'b0000} + hv;
    assign limit  = inside_reg ? char_gap_reg : frame_gap_reg;

    always_comb begin
        phase_next      = phase_reg;
        body_count_next = body_count_reg;
        xor_next        = xor_reg;
        hex_seen_next   = hex_seen_reg;
        hex_high_next   = hex_high_reg;
        idle_next       = idle_reg;
        inside_next     = inside_reg;
        res_next        = '0;
        res_next.event_res  = nsf_pkg::EV_NONE;
        res_next.drop_cause = nsf_pkg::CAUSE_NONE;

        if (!s_tuser) begin
            idle_next = '0;
            unique case (phase_reg)
                PH_WAIT_START: begin
                    if (s_tdata == nsf_pkg::CH_DOLLAR) begin
                        xor_next           = '0;
                        body_count_next    = '0;
                        inside_next        = 1'b1;
                        phase_next         = PH_BODY;
                        res_next.event_res = nsf_pkg::EV_START;
                    end
                end
                PH_BODY: begin
                    if (s_tdata == nsf_pkg::CH_CR) begin
                        phase_next = PH_WAIT_LF;
                    end else if (s_tdata == nsf_pkg::CH_STAR) begin
                        hex_seen_next = 1'b0;
                        phase_next    = PH_CHECKSUM;
                    end else if (body_count_reg >= BODY_LIMIT) begin
                        res_next.event_res  = nsf_pkg::EV_DROP;
                        res_next.drop_cause = nsf_pkg::CAUSE_TOO_LONG;
                        phase_next          = PH_WAIT_START;
                        inside_next         = 1'b0;
                    end else begin
                        xor_next            = xor_reg ^ s_tdata;
                        res_next.body_char  = (s_tdata == nsf_pkg::CH_COMMA) ? 8'd0 : s_tdata;
                        res_next.char_index = body_count_reg;
                        body_count_next     = body_count_reg + 7'd1;
                        res_next.event_res  = nsf_pkg::EV_CHAR;
                    end
                end
                PH_WAIT_LF: begin
                    if (s_tdata == nsf_pkg::CH_LF) begin
                        res_next.event_res = nsf_pkg::EV_COMPLETE;
                    end else begin
                        res_next.event_res  = nsf_pkg::EV_DROP;
                        res_next.drop_cause = nsf_pkg::CAUSE_NO_LF;
                    end
                    phase_next  = PH_WAIT_START;
                    inside_next = 1'b0;
                end
                PH_CHECKSUM: begin
                    if (!hex_seen_reg) begin
                        hex_high_next = hv;
                        hex_seen_next = 1'b1;
                    end else begin
                        hex_seen_next = 1'b0;
                        if (rx_sum == xor_reg) begin
                            phase_next         = PH_BODY;
                            res_next.event_res = nsf_pkg::EV_CS_OK;
                        end else begin
                            res_next.event_res  = nsf_pkg::EV_DROP;
                            res_next.drop_cause = nsf_pkg::CAUSE_CHECKSUM;
                            phase_next          = PH_WAIT_START;
                            inside_next         = 1'b0;
                        end
                    end
                end
                default: begin
                    phase_next = PH_WAIT_START;
                end
            endcase
        end else begin
            if (idle_reg != 16'hFFFF) begin
                idle_next = idle_reg + 16'd1;
            end
            if (idle_next >= limit) begin
                phase_next         = PH_WAIT_START;
                inside_next        = 1'b0;
                res_next.event_res = nsf_pkg::EV_TIMEOUT;
            end
        end

        res_next.body_length = body_count_next;
        res_next.running_xor = xor_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_gap_reg <= nsf_pkg::FRAME_GAP_RESET;
            char_gap_reg  <= nsf_pkg::CHAR_GAP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                nsf_pkg::REG_FRAME_GAP: frame_gap_reg <= cfg_data;
                nsf_pkg::REG_CHAR_GAP:  char_gap_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WAIT_START;
            body_count_reg <= '0;
            xor_reg        <= '0;
            hex_seen_reg   <= 1'b0;
            hex_high_reg   <= '0;
            idle_reg       <= '0;
            inside_reg     <= 1'b0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            body_count_reg <= body_count_next;
            xor_reg        <= xor_next;
            hex_seen_reg   <= hex_seen_next;
            hex_high_reg   <= hex_high_next;
            idle_reg       <= idle_next;
            inside_reg     <= inside_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res_next;
            end
        end else if (accept) begin
            skid_reg <= res_next;
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_inside_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        inside_reg == (phase_reg != PH_WAIT_START))
        else $error("sentence flag disagrees with phase");

    a_body_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        body_count_reg <= BODY_LIMIT)
        else $error("body count beyond frame limit");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && accept) |=> skid_valid_reg)
        else $error("word accepted during stall not held in skid register");

endmodule
